>>> design/cpb_pkg.sv
// cpb_pkg: shared types, constants and the crc byte update for the packet header builder
// no dependencies

package cpb_pkg;

  localparam logic [7:0]  MAX_PAYLOAD = 8'd250;
  localparam logic [7:0]  MAGIC_VALUE = 8'h55;
  localparam logic [15:0] CRC_SEED    = 16'hFFFF;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] magic_byte;
    logic [7:0] frame_length;
    logic [7:0] body_crc_low;
    logic [7:0] body_crc_high;
    logic [7:0] head_check;
    logic       too_long;
  } out_t;

  typedef struct packed {
    logic [7:0]  frame_length;
    logic [15:0] body_crc;
    logic        too_long;
  } hdr_t;

  // crc-16 poly 0x1021, msb first, one byte in parallel form
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [7:0] x;
    x = crc[15:8] ^ b;
    x = x ^ (x >> 4);
    return {crc[7:0], 8'h00} ^ {x[3:0], 12'h000} ^ {3'b000, x, 5'b00000} ^ {8'h00, x};
  endfunction

endpackage

>>> design/cpb_in_reg.sv
// cpb_in_reg: input register of the header builder pipeline
// depends on cpb_pkg

module cpb_in_reg
  import cpb_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic stg_valid_o,
  input  logic stg_ready_i,
  output in_t  stg_data_o
);

  logic valid_q, valid_d;
  in_t  data_q;
  logic ready;

  assign ready      = !valid_q || stg_ready_i;
  assign in_stall_o = !ready;
  assign valid_d    = ready ? in_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && ready) begin
      data_q <= in_data_i;
    end
  end

  assign stg_valid_o = valid_q;
  assign stg_data_o  = data_q;

endmodule

>>> design/cpb_accum.sv
// cpb_accum: running crc, byte count and overflow state, header register on the last byte
// depends on cpb_pkg

module cpb_accum
  import cpb_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic stg_valid_i,
  output logic stg_ready_o,
  input  in_t  stg_data_i,
  output logic hdr_valid_o,
  input  logic hdr_ready_i,
  output hdr_t hdr_data_o
);

  logic [15:0] crc_q, crc_d;
  logic [7:0]  count_q, count_d;
  logic        ovf_q, ovf_d;
  logic        valid_q, valid_d;
  hdr_t        hdr_q;
  logic        ready;
  logic        take;
  logic [15:0] crc_upd;
  logic [7:0]  count_upd;
  logic        ovf_upd;

  assign ready       = !valid_q || hdr_ready_i;
  assign stg_ready_o = ready;
  assign take        = stg_valid_i && ready;

  always_comb begin
    if (count_q < MAX_PAYLOAD) begin
      crc_upd   = crc_byte(crc_q, stg_data_i.payload_byte);
      count_upd = count_q + 8'd1;
      ovf_upd   = ovf_q;
    end else begin
      crc_upd   = crc_q;
      count_upd = count_q;
      ovf_upd   = 1'b1;
    end
  end

  always_comb begin
    crc_d   = crc_q;
    count_d = count_q;
    ovf_d   = ovf_q;
    valid_d = ready ? 1'b0 : valid_q;
    if (take) begin
      if (stg_data_i.last_byte) begin
        crc_d   = CRC_SEED;
        count_d = 8'd0;
        ovf_d   = 1'b0;
        valid_d = 1'b1;
      end else begin
        crc_d   = crc_upd;
        count_d = count_upd;
        ovf_d   = ovf_upd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q   <= CRC_SEED;
      count_q <= 8'd0;
      ovf_q   <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      crc_q   <= crc_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && stg_data_i.last_byte) begin
      hdr_q.frame_length <= count_upd;
      hdr_q.body_crc     <= crc_upd;
      hdr_q.too_long     <= ovf_upd;
    end
  end

  assign hdr_valid_o = valid_q;
  assign hdr_data_o  = hdr_q;

endmodule

>>> design/cpb_head.sv
// cpb_head: header check over length and crc bytes, result register
// depends on cpb_pkg

module cpb_head
  import cpb_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic hdr_valid_i,
  output logic hdr_ready_o,
  input  hdr_t hdr_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  logic        valid_q, valid_d;
  out_t        data_q, data_d;
  logic        ready;
  logic [15:0] hc0, hc1, hc2;

  assign ready       = !valid_q || !out_stall_i;
  assign hdr_ready_o = ready;
  assign valid_d     = ready ? hdr_valid_i : valid_q;

  always_comb begin
    hc0 = crc_byte(CRC_SEED, hdr_data_i.frame_length);
    hc1 = crc_byte(hc0, hdr_data_i.body_crc[7:0]);
    hc2 = crc_byte(hc1, hdr_data_i.body_crc[15:8]);
    data_d.magic_byte    = MAGIC_VALUE;
    data_d.frame_length  = hdr_data_i.frame_length;
    data_d.body_crc_low  = hdr_data_i.body_crc[7:0];
    data_d.body_crc_high = hdr_data_i.body_crc[15:8];
    data_d.head_check    = hc2[7:0];
    data_d.too_long      = hdr_data_i.too_long;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hdr_valid_i && ready) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

>>> design/crc_packet_header_builder_unit.sv
// crc_packet_header_builder_unit: top level of the packet header builder
// depends on cpb_pkg, cpb_in_reg, cpb_accum, cpb_head
//
//   channel  dir  handshake              payload
//   in       in   in_valid_i/in_stall_o  in_data_i  (payload_byte, last_byte)
//   out      out  out_valid_o/out_stall_i out_data_o (header fields, too_long)
//
// one byte per cycle sustained while out is not stalled; the crc state register updates once per accepted byte
// a header reaches out after its last byte is accepted, passing through the input, header and result regs
// reset clears the crc to 0xffff, the count and overflow flag, and all valid bits
// a stall on out backs up through the stages; in_stall_o rises only when all three are full

module crc_packet_header_builder_unit
  import cpb_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  logic stg_valid, stg_ready;
  in_t  stg_data;
  logic hdr_valid, hdr_ready;
  hdr_t hdr_data;

  cpb_in_reg u_in_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .stg_valid_o (stg_valid),
    .stg_ready_i (stg_ready),
    .stg_data_o  (stg_data)
  );

  cpb_accum u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .stg_valid_i (stg_valid),
    .stg_ready_o (stg_ready),
    .stg_data_i  (stg_data),
    .hdr_valid_o (hdr_valid),
    .hdr_ready_i (hdr_ready),
    .hdr_data_o  (hdr_data)
  );

  cpb_head u_head (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .hdr_valid_i (hdr_valid),
    .hdr_ready_o (hdr_ready),
    .hdr_data_i  (hdr_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> design/cpb_checker.sv
// cpb_checker: port level assertions for the packet header builder, bound to the top level
// depends on cpb_pkg and crc_packet_header_builder_unit

module cpb_checker
  import cpb_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input in_t  in_data_i,
  input logic out_valid_o,
  input logic out_stall_i,
  input out_t out_data_o
);

  // stalled result transaction holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // stalled input transaction holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_data_i))
    else $error("stalled input changed");

  a_magic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.magic_byte == MAGIC_VALUE)
    else $error("bad magic byte");

  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.frame_length != 8'd0 && out_data_o.frame_length <= MAX_PAYLOAD)
    else $error("frame length out of range");

  a_overflow_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.too_long |-> out_data_o.frame_length == MAX_PAYLOAD)
    else $error("overflow without saturated length");

endmodule

bind crc_packet_header_builder_unit cpb_checker u_cpb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
